// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables for the differential-drive odometry block
package ddo_pkg;

  localparam int COUNT_WIDTH_DEF   = 10;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam logic [1:0] REQ_EDGE_A  = 2'd0;
  localparam logic [1:0] REQ_EDGE_B  = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;

  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] CFG_RADIUS_TRACK = 2'd1;
  localparam logic [1:0] CFG_RPM_PER_TICK = 2'd2;
  localparam logic [1:0] CFG_REFRESH      = 2'd3;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd2130;
  localparam logic [19:0] RADIUS_TRACK_RST = 20'd21299;
  localparam logic [23:0] RPM_PER_TICK_RST = 24'd204800;
  localparam logic [15:0] REFRESH_RST      = 16'd3277;

  localparam logic [27:0] SPEED_MAX   = 28'd209715200;
  localparam logic [24:0] FULL_TURN   = 25'd23592960;
  localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
  localparam logic [31:0] PI_OVER_60  = 32'd224883962;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [33:0] DEG90_Q24   = 34'sd1509949440;
  localparam logic signed [33:0] DEG180_Q24  = 34'sd3019898880;

  typedef struct packed {
    logic              done;
    logic signed [32:0] cos_v;
    logic signed [32:0] sin_v;
  } cordic_res_t;

  // atan(2^-i) in degrees, Q6.24
  function automatic logic [29:0] atan_q24(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ddo_queue.sv =====
// two-entry queue between the front and the back
module ddo_queue #(
  parameter int W = 2 * ddo_pkg::COUNT_WIDTH_DEF + 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] data
);
  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// ===== rtl/ddo_front.sv =====
// front end: accepts requests, counts edges, snapshots counts on refresh
module ddo_front #(
  parameter int CW = ddo_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      req_type,
  input  logic            fwd_a,
  input  logic            fwd_b,
  input  logic            q_full,
  output logic            push_valid,
  output logic [2*CW+1:0] push_data
);
  import ddo_pkg::*;

  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic          accept;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (req_type == REQ_REFRESH);
  assign push_data  = {fwd_b, fwd_a, cnt_b, cnt_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (accept) begin
      case (req_type)
        REQ_EDGE_A: begin
          if (cnt_a != '1) cnt_a <= cnt_a + 1'b1;
        end
        REQ_EDGE_B: begin
          if (cnt_b != '1) cnt_b <= cnt_b + 1'b1;
        end
        REQ_REFRESH: begin
          cnt_a <= '0;
          cnt_b <= '0;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== rtl/ddo_cordic.sv =====
// iterative rotation cordic, one micro-rotation per cycle, angles in degrees
module ddo_cordic #(
  parameter int STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [24:0]  angle,
  output ddo_pkg::cordic_res_t res
);
  import ddo_pkg::*;

  localparam int ITERS = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
  localparam int IW    = $clog2(ITERS + 1);

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic [IW-1:0]      iter;
  logic               busy;
  logic               done;
  logic signed [33:0] z0;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [33:0] at;

  assign z0 = 34'(angle) <<< 8;
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed({4'b0, atan_q24(5'(iter))});

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      iter <= '0;
      // fold into the right half plane, negate the result afterwards
      if (z0 > DEG90_Q24) begin
        z    <= z0 - DEG180_Q24;
        flip <= 1'b1;
      end else if (z0 < -DEG90_Q24) begin
        z    <= z0 + DEG180_Q24;
        flip <= 1'b1;
      end else begin
        z    <= z0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (iter == IW'(ITERS - 1))) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  assign res.done  = done;
  assign res.cos_v = flip ? -x : x;
  assign res.sin_v = flip ? -y : y;
endmodule

// ===== rtl/ddo_back.sv =====
// back end: speeds, pose integration and heading wrap on a shared multiplier
module ddo_back #(
  parameter int CW     = ddo_pkg::COUNT_WIDTH_DEF,
  parameter int STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [2*CW+1:0]    q_data,
  output logic               q_pop,
  input  logic [15:0]        wheel_radius,
  input  logic [19:0]        radius_over_track,
  input  logic [23:0]        rpm_per_tick,
  input  logic [15:0]        refresh_period,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [24:0] heading,
  output logic signed [28:0] speed_a,
  output logic signed [28:0] speed_b,
  output logic               stopped_a,
  output logic               stopped_b
);
  import ddo_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [3:0] ST_SPD_A   = 4'd0;
  localparam logic [3:0] ST_SPD_B   = 4'd1;
  localparam logic [3:0] ST_BASE_R  = 4'd2;
  localparam logic [3:0] ST_BASE_T  = 4'd3;
  localparam logic [3:0] ST_BASE_PI = 4'd4;
  localparam logic [3:0] ST_DH_ROT  = 4'd5;
  localparam logic [3:0] ST_DH_T    = 4'd6;
  localparam logic [3:0] ST_DX      = 4'd7;
  localparam logic [3:0] ST_DY      = 4'd8;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_30 = 2'd2;
  localparam logic [1:0] SH_32 = 2'd3;

  localparam logic [3:0] MOD_TOP = 4'd13;

  logic [2:0]  state;
  logic [3:0]  step;
  logic [3:0]  k;

  logic [CW-1:0]      cnt_a;
  logic [CW-1:0]      cnt_b;
  logic               fa;
  logic               fb;
  logic signed [28:0] spd_a;
  logic signed [28:0] spd_b;
  logic signed [31:0] base;
  logic signed [37:0] dh;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [24:0] pose_heading;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [38:0]        m;
  logic               hneg;

  logic [65:0] prod;
  logic        p_neg;
  logic [1:0]  p_sh;

  logic signed [40:0] a_val;
  logic [40:0]        a_abs;
  logic [31:0]        b_mag;
  logic               b_neg;
  logic [1:0]         sh;
  logic [18:0]        t6;
  logic [32:0]        c_abs;
  logic [32:0]        s_abs;
  logic [66:0]        rsum;
  logic [39:0]        res_mag;
  logic signed [40:0] res_s;
  logic [27:0]        mag28;
  logic signed [29:0] sum_s;
  logic signed [29:0] diff_s;
  logic signed [38:0] hsum;
  logic [38:0]        full_sh;
  logic signed [25:0] r;
  logic signed [25:0] hw;
  logic signed [33:0] sx;
  logic signed [33:0] sy;
  logic signed [31:0] px_next;
  logic signed [31:0] py_next;
  logic               start;

  cordic_res_t cres;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign start = q_pop;

  ddo_cordic #(.STAGES(STAGES)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .angle (pose_heading),
    .res   (cres)
  );

  assign t6     = ({3'b0, refresh_period} << 2) + ({3'b0, refresh_period} << 1);
  assign c_abs  = cres.cos_v[32] ? 33'(-cres.cos_v) : 33'(cres.cos_v);
  assign s_abs  = cres.sin_v[32] ? 33'(-cres.sin_v) : 33'(cres.sin_v);
  assign sum_s  = 30'(spd_a) + 30'(spd_b);
  assign diff_s = 30'(spd_a) - 30'(spd_b);

  always_comb begin
    a_val = '0;
    b_mag = '0;
    b_neg = 1'b0;
    sh    = SH_0;
    case (step)
      ST_SPD_A: begin
        a_val = $signed({{(41 - CW){1'b0}}, cnt_a});
        b_mag = 32'(rpm_per_tick);
      end
      ST_SPD_B: begin
        a_val = $signed({{(41 - CW){1'b0}}, cnt_b});
        b_mag = 32'(rpm_per_tick);
      end
      ST_BASE_R: begin
        a_val = 41'(sum_s);
        b_mag = 32'(wheel_radius);
        sh    = SH_16;
      end
      ST_BASE_T: begin
        a_val = 41'(base);
        b_mag = 32'(refresh_period);
        sh    = SH_16;
      end
      ST_BASE_PI: begin
        a_val = 41'(base);
        b_mag = PI_OVER_60;
        sh    = SH_32;
      end
      ST_DH_ROT: begin
        a_val = 41'(diff_s);
        b_mag = 32'(radius_over_track);
        sh    = SH_16;
      end
      ST_DH_T: begin
        // the times-six is folded into the period operand
        a_val = 41'(dh);
        b_mag = 32'(t6);
        sh    = SH_16;
      end
      ST_DX: begin
        a_val = 41'(base);
        b_mag = c_abs[31:0];
        b_neg = cres.cos_v[32];
        sh    = SH_30;
      end
      ST_DY: begin
        a_val = 41'(base);
        b_mag = s_abs[31:0];
        b_neg = cres.sin_v[32];
        sh    = SH_30;
      end
      default: begin
      end
    endcase
  end

  assign a_abs = a_val[40] ? 41'(-a_val) : 41'(a_val);

  // round half away from zero on the magnitude
  always_comb begin
    case (p_sh)
      SH_0:    rsum = 67'(prod);
      SH_16:   rsum = (67'(prod) + (67'd1 << 15)) >> 16;
      SH_30:   rsum = (67'(prod) + (67'd1 << 29)) >> 30;
      SH_32:   rsum = (67'(prod) + (67'd1 << 31)) >> 32;
      default: rsum = 67'(prod);
    endcase
  end

  assign res_mag = rsum[39:0];
  assign res_s   = p_neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  assign mag28   = (res_mag > 40'(SPEED_MAX)) ? SPEED_MAX : res_mag[27:0];

  assign hsum    = 39'(pose_heading) + 39'(dh);
  assign full_sh = 39'(FULL_TURN) << k;

  always_comb begin
    r = hneg ? -$signed(26'(m)) : $signed(26'(m));
    if (r <= -HALF_TURN) begin
      hw = r + $signed({1'b0, FULL_TURN});
    end else if (r > HALF_TURN) begin
      hw = r - $signed({1'b0, FULL_TURN});
    end else begin
      hw = r;
    end
  end

  assign sx = 34'(pose_x) + 34'(dx);
  assign sy = 34'(pose_y) + 34'(dy);
  assign px_next = (sx > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                   (sx < -34'sh080000000) ? 32'sh80000000 : sx[31:0];
  assign py_next = (sy > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                   (sy < -34'sh080000000) ? 32'sh80000000 : sy[31:0];

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          cnt_a <= q_data[CW-1:0];
          cnt_b <= q_data[2*CW-1:CW];
          fa    <= q_data[2*CW];
          fb    <= q_data[2*CW+1];
        end
      end
      S_MUL: begin
        prod  <= 66'(a_abs[33:0]) * 66'(b_mag);
        p_neg <= a_val[40] ^ b_neg;
        p_sh  <= sh;
      end
      S_RND: begin
        case (step)
          ST_SPD_A: spd_a <= fa ? $signed({1'b0, mag28}) : -$signed({1'b0, mag28});
          ST_SPD_B: spd_b <= fb ? $signed({1'b0, mag28}) : -$signed({1'b0, mag28});
          ST_BASE_R, ST_BASE_T, ST_BASE_PI: base <= res_s[31:0];
          ST_DH_ROT, ST_DH_T: dh <= res_s[37:0];
          ST_DX: dx <= res_s[32:0];
          ST_DY: begin
            dy   <= res_s[32:0];
            hneg <= hsum[38];
            m    <= hsum[38] ? 39'(-hsum) : 39'(hsum);
          end
          default: begin
          end
        endcase
      end
      S_MOD: begin
        if (m >= full_sh) m <= m - full_sh;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_SPD_A;
      k            <= MOD_TOP;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            step  <= ST_SPD_A;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // the pose steps need the cosine and sine
          if (step < ST_DX || cres.done) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          if (step == ST_DY) begin
            k     <= MOD_TOP;
            state <= S_MOD;
          end else begin
            step  <= step + 4'd1;
            state <= S_MUL;
          end
        end
        S_MOD: begin
          if (k == 4'd0) begin
            state <= S_DONE;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pose_x       <= px_next;
            pose_y       <= py_next;
            pose_heading <= hw[24:0];
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      pos_x     <= px_next;
      pos_y     <= py_next;
      heading   <= hw[24:0];
      speed_a   <= spd_a;
      speed_b   <= spd_b;
      stopped_a <= (cnt_a == '0);
      stopped_b <= (cnt_b == '0);
    end
  end
endmodule

// ===== rtl/diff_drive_encoder_odometry.sv =====
// edge requests are counted as they are accepted; a refresh tick gives one result, computed
// with nine products on one shared multiplier, each in a multiply and a round state, then a
// 14-step heading reduction; the cordic runs beside the multiplier. a two-entry queue lets
// edges keep arriving while a refresh is computed; a new refresh starts only after the last.
// synchronous reset clears counts, pose, queue and out_valid, and reloads register defaults.
module diff_drive_encoder_odometry #(
  parameter int COUNT_WIDTH   = ddo_pkg::COUNT_WIDTH_DEF,
  parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic               fwd_a,
  input  logic               fwd_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [24:0] heading,
  output logic signed [28:0] speed_a,
  output logic signed [28:0] speed_b,
  output logic               stopped_a,
  output logic               stopped_b,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import ddo_pkg::*;

  localparam int QW = 2 * COUNT_WIDTH + 2;

  logic [15:0] wheel_radius;
  logic [19:0] radius_over_track;
  logic [23:0] rpm_per_tick;
  logic [15:0] refresh_period;

  logic          push_valid;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_valid;
  logic [QW-1:0] q_data;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius      <= WHEEL_RADIUS_RST;
      radius_over_track <= RADIUS_TRACK_RST;
      rpm_per_tick      <= RPM_PER_TICK_RST;
      refresh_period    <= REFRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_RADIUS: wheel_radius      <= cfg_data[15:0];
        CFG_RADIUS_TRACK: radius_over_track <= cfg_data[19:0];
        CFG_RPM_PER_TICK: rpm_per_tick      <= cfg_data;
        CFG_REFRESH:      refresh_period    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  ddo_front #(.CW(COUNT_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .fwd_a      (fwd_a),
    .fwd_b      (fwd_b),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  ddo_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_data)
  );

  ddo_back #(.CW(COUNT_WIDTH), .STAGES(CORDIC_STAGES)) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .wheel_radius      (wheel_radius),
    .radius_over_track (radius_over_track),
    .rpm_per_tick      (rpm_per_tick),
    .refresh_period    (refresh_period),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .heading           (heading),
    .speed_a           (speed_a),
    .speed_b           (speed_b),
    .stopped_a         (stopped_a),
    .stopped_b         (stopped_b)
  );
endmodule

// ===== rtl/ddo_checker.sv =====
// port-level checks for the odometry block, bound to the top level
module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [24:0] heading,
  input logic signed [28:0] speed_a,
  input logic signed [28:0] speed_b,
  input logic               stopped_a,
  input logic               stopped_b
);
  import ddo_pkg::*;

  // a stalled result transaction stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (26'(heading) > -HALF_TURN) && (26'(heading) <= HALF_TURN))
    else $error("heading outside the half-open turn");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_a <= $signed({1'b0, SPEED_MAX})) &&
                  (speed_a >= -$signed({1'b0, SPEED_MAX})) &&
                  (speed_b <= $signed({1'b0, SPEED_MAX})) &&
                  (speed_b >= -$signed({1'b0, SPEED_MAX})))
    else $error("wheel speed beyond saturation");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!stopped_a || speed_a == '0) && (!stopped_b || speed_b == '0))
    else $error("stopped wheel with nonzero speed");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");
endmodule

bind diff_drive_encoder_odometry ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .heading   (heading),
  .speed_a   (speed_a),
  .speed_b   (speed_b),
  .stopped_a (stopped_a),
  .stopped_b (stopped_b)
);
